FILE: rtl/core/rmq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion package
// Shared types for the classifier front end and the arithmetic back end.
// ----------------------------------------------------------------------------
package rmq_pkg;

    typedef enum logic [1:0] {
        BR_W = 2'd0,
        BR_X = 2'd1,
        BR_Y = 2'd2,
        BR_Z = 2'd3
    } t_branch;

    // Fraction bits of every element and component (Q2.14).
    localparam int FRAC_BITS = 14;
    localparam int ELEM_W = 16;
    // Radicand needs at most 18 bits signed (2^14 + 3 * 2^15).
    localparam int RAD_W  = 20;
    localparam int DIFF_W = 17;

    typedef struct packed {
        t_branch                    branch;
        logic                       bad;
        logic signed [RAD_W-1:0]    rad;
        logic signed [DIFF_W-1:0]   d0;
        logic signed [DIFF_W-1:0]   d1;
        logic signed [DIFF_W-1:0]   d2;
    } t_job;

endpackage
`default_nettype wire

FILE: rtl/core/rmq_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Front end
// Picks the branch by trace and diagonal, forms the radicand and the three
// off-diagonal sums or differences, and registers the job.
// ----------------------------------------------------------------------------
module rmq_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    input  wire signed [15:0]     i_m_xx, i_m_xy, i_m_xz,
    input  wire signed [15:0]     i_m_yx, i_m_yy, i_m_yz,
    input  wire signed [15:0]     i_m_zx, i_m_zy, i_m_zz,
    output logic                  o_valid,
    output rmq_pkg::t_job         o_job
);
    localparam int FRAC_BITS = rmq_pkg::FRAC_BITS;
    localparam int RW = rmq_pkg::RAD_W;
    localparam int DW = rmq_pkg::DIFF_W;
    localparam logic signed [RW-1:0] ONE = RW'(1) <<< FRAC_BITS;

    logic signed [RW-1:0] xx, yy, zz, tr;
    logic signed [DW-1:0] xy, xz, yx, yz, zx, zy;
    rmq_pkg::t_job n_job, r_job;
    logic r_valid;

    always_comb begin
        xx = RW'(i_m_xx); yy = RW'(i_m_yy); zz = RW'(i_m_zz);
        xy = DW'(i_m_xy); xz = DW'(i_m_xz); yx = DW'(i_m_yx);
        yz = DW'(i_m_yz); zx = DW'(i_m_zx); zy = DW'(i_m_zy);
        tr = xx + yy + zz;
        if (tr > 0) begin
            n_job.branch = rmq_pkg::BR_W;
            n_job.rad = ONE + tr;
            n_job.d0 = yz - zy; n_job.d1 = zx - xz; n_job.d2 = xy - yx;
        end else if (xx > yy && xx > zz) begin
            n_job.branch = rmq_pkg::BR_X;
            n_job.rad = ONE + xx - yy - zz;
            n_job.d0 = yz - zy; n_job.d1 = xy + yx; n_job.d2 = zx + xz;
        end else if (yy > zz) begin
            n_job.branch = rmq_pkg::BR_Y;
            n_job.rad = ONE + yy - xx - zz;
            n_job.d0 = zx - xz; n_job.d1 = xy + yx; n_job.d2 = yz + zy;
        end else begin
            n_job.branch = rmq_pkg::BR_Z;
            n_job.rad = ONE + zz - xx - yy;
            n_job.d0 = xy - yx; n_job.d1 = zx + xz; n_job.d2 = yz + zy;
        end
        n_job.bad = (n_job.rad <= 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_job <= n_job;
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;
endmodule
`default_nettype wire

FILE: rtl/core/rmq_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Job queue
// Two-entry skid stage between front and back end.
// ----------------------------------------------------------------------------
module rmq_fifo (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  rmq_pkg::t_job   i_job,
    input  wire             i_pop,
    output logic            o_valid,
    output rmq_pkg::t_job   o_job,
    output logic            o_empty
);
    rmq_pkg::t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic do_pop;

    assign do_pop  = i_pop && (r_cnt != 2'd0);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign o_empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(do_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/rmq_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Back end
// Pipelined square root (one result bit per stage), then three pipelined
// restoring dividers (one quotient bit per stage), rounding and saturation.
// ----------------------------------------------------------------------------
module rmq_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  rmq_pkg::t_job       i_job,
    output logic                o_valid,
    output logic signed [15:0]  o_q_x,
    output logic signed [15:0]  o_q_y,
    output logic signed [15:0]  o_q_z,
    output logic signed [15:0]  o_q_w,
    output logic                o_bad_input
);
    localparam int FRAC_BITS = rmq_pkg::FRAC_BITS;
    localparam int RW   = rmq_pkg::RAD_W;
    localparam int DW   = rmq_pkg::DIFF_W;
    // Radicand shifted left by FRAC_BITS-2; root has half as many bits.
    localparam int VW   = RW + FRAC_BITS;
    localparam int SS   = (VW + 1) / 2;
    localparam int SQW  = SS + 1;
    // Numerator 2*|d|*2^FRAC + 4*sq, divided by 8*sq: round half away.
    localparam int NW   = DW + FRAC_BITS + 2;
    localparam int DENW = SQW + 3;
    // Quotients above 65536 saturate anyway; 18 bits then suffice.
    localparam int QB   = 18;
    localparam int CW   = NW + DENW;

    typedef struct packed {
        rmq_pkg::t_branch       branch;
        logic                   bad;
        logic signed [DW-1:0]   d0, d1, d2;
    } t_side;

    // Square root pipeline.
    logic [VW-1:0]  s_rem  [SS+1];
    logic [SQW-1:0] s_root [SS+1];
    t_side          s_side [SS+1];
    logic           s_vld  [SS+1];

    always_comb begin
        s_rem[0]  = i_job.bad ? '0 : VW'($unsigned(i_job.rad)) << (FRAC_BITS - 2);
        s_root[0] = '0;
        s_side[0] = '{i_job.branch, i_job.bad, i_job.d0, i_job.d1, i_job.d2};
        s_vld[0]  = i_valid;
    end

    for (genvar k = 0; k < SS; k++) begin : g_sqrt
        localparam int SH = 2 * (SS - 1 - k);
        logic [VW+1:0] trial;
        logic [VW+1:0] remw;
        always_comb begin
            trial = ((VW+2)'(s_root[k]) << 2 | (VW+2)'(1)) << SH;
            remw  = (VW+2)'(s_rem[k]);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                s_vld[k+1] <= 1'b0;
            end else begin
                s_vld[k+1] <= s_vld[k];
            end
            s_side[k+1] <= s_side[k];
            if (remw >= trial) begin
                s_rem[k+1]  <= VW'(remw - trial);
                s_root[k+1] <= (s_root[k] << 1) | SQW'(1);
            end else begin
                s_rem[k+1]  <= s_rem[k];
                s_root[k+1] <= s_root[k] << 1;
            end
        end
    end

    // Division pipeline, three lanes; indexed by stage, then lane.
    logic [NW-1:0]   v_rem [QB+1][3];
    logic [QB-1:0]   v_quo [QB+1][3];
    logic [2:0]      v_neg [QB+1];
    logic [DENW-1:0] v_den [QB+1];
    logic [SQW-1:0]  v_sq  [QB+1];
    t_side           v_side[QB+1];
    logic            v_vld [QB+1];

    logic signed [DW-1:0] din [3];
    always_comb begin
        din[0] = s_side[SS].d0; din[1] = s_side[SS].d1; din[2] = s_side[SS].d2;
        v_den[0]  = DENW'(s_root[SS]) << 3;
        v_sq[0]   = s_root[SS];
        v_side[0] = s_side[SS];
        v_vld[0]  = s_vld[SS];
        for (int l = 0; l < 3; l++) begin
            v_neg[0][l] = din[l][DW-1];
            // The magnitude of the most negative sum needs all DW bits unsigned.
            v_rem[0][l] = ((NW'($unsigned(din[l][DW-1] ? -din[l] : din[l]))
                           << (FRAC_BITS + 1)) + (NW'(s_root[SS]) << 2));
            v_quo[0][l] = '0;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_div
        localparam int SH = QB - 1 - k;
        logic [CW-1:0] dsh;
        assign dsh = CW'(v_den[k]) << SH;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                v_vld[k+1] <= 1'b0;
            end else begin
                v_vld[k+1] <= v_vld[k];
            end
            v_side[k+1] <= v_side[k];
            v_den[k+1]  <= v_den[k];
            v_sq[k+1]   <= v_sq[k];
            v_neg[k+1]  <= v_neg[k];
            for (int l = 0; l < 3; l++) begin
                if (CW'(v_rem[k][l]) >= dsh) begin
                    v_rem[k+1][l] <= NW'(CW'(v_rem[k][l]) - dsh);
                    v_quo[k+1][l] <= v_quo[k][l] | (QB'(1) << SH);
                end else begin
                    v_rem[k+1][l] <= v_rem[k][l];
                    v_quo[k+1][l] <= v_quo[k][l];
                end
            end
        end
    end

    // Rounding and saturation.
    function automatic logic signed [15:0] sat_mag(input logic [QB-1:0] q,
                                                    input logic neg);
        logic signed [QB:0] s;
        begin
            s = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
            if (s > 32767) begin
                sat_mag = 16'sh7fff;
            end else if (s < -32768) begin
                sat_mag = -16'sh8000;
            end else begin
                sat_mag = 16'(s);
            end
        end
    endfunction

    logic signed [15:0] t [3];
    logic signed [15:0] own;
    logic signed [15:0] n_x, n_y, n_z, n_w;
    logic [QB-1:0] qd [3];
    t_side fin;

    always_comb begin
        fin = v_side[QB];
        for (int l = 0; l < 3; l++) begin
            // Only a bad job brings sq of zero here: a positive radicand gives sq >= 1.
            qd[l] = v_quo[QB][l];
            t[l]  = sat_mag(qd[l], v_neg[QB][l]);
        end
        own = (v_sq[QB] > SQW'(32767)) ? 16'sh7fff : 16'(v_sq[QB]);
        n_x = '0; n_y = '0; n_z = '0; n_w = '0;
        unique case (fin.branch)
            rmq_pkg::BR_W: begin
                n_w = own; n_x = t[0]; n_y = t[1]; n_z = t[2];
            end
            rmq_pkg::BR_X: begin
                n_x = own; n_w = t[0]; n_y = t[1]; n_z = t[2];
            end
            rmq_pkg::BR_Y: begin
                n_y = own; n_w = t[0]; n_x = t[1]; n_z = t[2];
            end
            default: begin
                n_z = own; n_w = t[0]; n_x = t[1]; n_y = t[2];
            end
        endcase
        if (fin.bad) begin
            n_x = '0; n_y = '0; n_z = '0; n_w = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= v_vld[QB];
        end
        o_q_x <= n_x; o_q_y <= n_y; o_q_z <= n_z; o_q_w <= n_w;
        o_bad_input <= fin.bad;
    end
endmodule
`default_nettype wire

FILE: rtl/core/rotation_matrix_to_quaternion_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion core
// Converts a 3x3 rotation matrix in signed fixed point to a quaternion.
// ----------------------------------------------------------------------------
// Usage: drive the nine matrix elements and raise start; the transaction is
// taken at a clock edge where start is high and busy is low. Busy stays low
// in normal operation, so one matrix may be given every cycle.
// The front end registers the branch choice, radicand and off-diagonal
// terms; a two-entry queue passes each job to the back end, which runs a
// pipelined square root (one root bit per stage) and three pipelined
// dividers (one quotient bit per stage). A result passes the front
// register, the queue, 17 root stages, 18 divider stages and the output
// register in that order; throughput is one matrix per cycle.
// Each result appears for one cycle with o_valid high; the receiver cannot
// stall. bad_input flags a non-positive radicand, with all components zero.
// Synchronous reset empties the pipeline; no result is in flight after it.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire signed [15:0]   i_m_xx, i_m_xy, i_m_xz,
    input  wire signed [15:0]   i_m_yx, i_m_yy, i_m_yz,
    input  wire signed [15:0]   i_m_zx, i_m_zy, i_m_zz,
    output logic                o_valid,
    output logic signed [15:0]  o_q_x,
    output logic signed [15:0]  o_q_y,
    output logic signed [15:0]  o_q_z,
    output logic signed [15:0]  o_q_w,
    output logic                o_bad_input
);
    logic f_valid, q_valid, q_empty;
    rmq_pkg::t_job f_job, q_job;

    assign busy = 1'b0;

    rmq_front u_front (
        .i_clk, .i_rst_n, .i_valid(start && !busy),
        .i_m_xx, .i_m_xy, .i_m_xz, .i_m_yx, .i_m_yy, .i_m_yz,
        .i_m_zx, .i_m_zy, .i_m_zz,
        .o_valid(f_valid), .o_job(f_job)
    );

    // The back end never stalls, so the queue drains every cycle.
    rmq_fifo u_fifo (
        .i_clk, .i_rst_n, .i_push(f_valid), .i_job(f_job),
        .i_pop(1'b1), .o_valid(q_valid), .o_job(q_job), .o_empty(q_empty)
    );

    rmq_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_job(q_job),
        .o_valid, .o_q_x, .o_q_y, .o_q_z, .o_q_w, .o_bad_input
    );

`ifndef SYNTHESIS
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_input |-> o_q_x == 0 && o_q_y == 0 && o_q_z == 0 && o_q_w == 0)
        else $error("bad input result has nonzero components");
    a_queue_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_valid |=> !q_empty)
        else $error("queue lost a job");
    a_start_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> f_valid)
        else $error("front end dropped a transaction");
`endif
endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion core testbench
// Drives a table of directed matrices, then random rotations and noise,
// and checks every quaternion in order against typed values or a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int FRAC   = rmq_pkg::FRAC_BITS;
    localparam int N_RAND = 1800;

    typedef struct {
        logic signed [15:0] m [9];
    } t_mat;

    typedef struct {
        logic signed [15:0] qx, qy, qz, qw;
        logic               bad;
    } t_quat;

    typedef struct {
        t_mat  mat;
        bit    typed;
        t_quat res;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] mi [9];
    logic               o_valid;
    logic signed [15:0] o_q_x, o_q_y, o_q_z, o_q_w;
    logic               o_bad_input;

    t_quat quat_queue [$];
    int    n_errors = 0;
    bit    stim_done = 1'b0;

    always #5 i_clk = ~i_clk;

    initial begin
        for (int k = 0; k < 9; k++) mi[k] = '0;
    end

    rotation_matrix_to_quaternion_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_m_xx(mi[0]), .i_m_xy(mi[1]), .i_m_xz(mi[2]),
        .i_m_yx(mi[3]), .i_m_yy(mi[4]), .i_m_yz(mi[5]),
        .i_m_zx(mi[6]), .i_m_zy(mi[7]), .i_m_zz(mi[8]),
        .o_valid(o_valid), .o_q_x(o_q_x), .o_q_y(o_q_y), .o_q_z(o_q_z),
        .o_q_w(o_q_w), .o_bad_input(o_bad_input)
    );

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint int_root(longint v);
        longint r = 0;
        longint b = 64'sd1 <<< 60;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - r - b;
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    // Off-diagonal term d / (4 * root), rounded to nearest with ties away.
    function automatic longint scaled_pair(longint d, longint root);
        longint mag = (d < 0) ? -d : d;
        longint den = root * 4;
        longint q;
        if (den == 0) return 0;
        q = ((mag <<< FRAC) + den / 2) / den;
        if (q > 65536) q = 65536;
        return clamp16((d < 0) ? -q : q);
    endfunction

    function automatic t_quat quat_of(t_mat a);
        longint xx = a.m[0], xy = a.m[1], xz = a.m[2];
        longint yx = a.m[3], yy = a.m[4], yz = a.m[5];
        longint zx = a.m[6], zy = a.m[7], zz = a.m[8];
        longint tr = xx + yy + zz;
        longint one = 64'sd1 <<< FRAC;
        longint rad, root, own;
        rmq_pkg::t_branch br;
        t_quat q;
        q = '{default: '0};
        if (tr > 0) begin
            br = rmq_pkg::BR_W; rad = one + tr;
        end else if (xx > yy && xx > zz) begin
            br = rmq_pkg::BR_X; rad = one + xx - yy - zz;
        end else if (yy > zz) begin
            br = rmq_pkg::BR_Y; rad = one + yy - xx - zz;
        end else begin
            br = rmq_pkg::BR_Z; rad = one + zz - xx - yy;
        end
        if (rad <= 0) begin
            q.bad = 1'b1;
            return q;
        end
        root = int_root(rad <<< (FRAC - 2));
        own = clamp16(root > 65536 ? 65536 : root);
        case (br)
            rmq_pkg::BR_W: begin
                q.qw = own; q.qx = scaled_pair(yz - zy, root);
                q.qy = scaled_pair(zx - xz, root); q.qz = scaled_pair(xy - yx, root);
            end
            rmq_pkg::BR_X: begin
                q.qx = own; q.qw = scaled_pair(yz - zy, root);
                q.qy = scaled_pair(xy + yx, root); q.qz = scaled_pair(zx + xz, root);
            end
            rmq_pkg::BR_Y: begin
                q.qy = own; q.qw = scaled_pair(zx - xz, root);
                q.qx = scaled_pair(xy + yx, root); q.qz = scaled_pair(yz + zy, root);
            end
            default: begin
                q.qz = own; q.qw = scaled_pair(xy - yx, root);
                q.qx = scaled_pair(zx + xz, root); q.qy = scaled_pair(yz + zy, root);
            end
        endcase
        return q;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        n_errors++;
    endtask

    // Sends one transaction, with an optional idle burst ahead of it.
    task automatic send_matrix(t_mat a, t_quat want, bit gaps);
        if (gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        start <= 1'b1;
        for (int k = 0; k < 9; k++) mi[k] <= a.m[k];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        quat_queue.push_back(want);
    endtask

    function automatic t_mat build(int a0, int a1, int a2, int a3, int a4,
                                   int a5, int a6, int a7, int a8);
        t_mat a;
        a.m = '{16'(a0), 16'(a1), 16'(a2), 16'(a3), 16'(a4),
                16'(a5), 16'(a6), 16'(a7), 16'(a8)};
        return a;
    endfunction

    function automatic t_mat noise_mat();
        t_mat a;
        for (int k = 0; k < 9; k++) a.m[k] = 16'($urandom);
        return a;
    endfunction

    // Random rotation from a random unit quaternion, nearly exact in Q2.14.
    function automatic t_mat rotation_mat();
        real w, x, y, z, n;
        real r [9];
        t_mat a;
        w = $urandom_range(0, 20000) - 10000.0; x = $urandom_range(0, 20000) - 10000.0;
        y = $urandom_range(0, 20000) - 10000.0; z = $urandom_range(0, 20000) - 10000.0;
        n = $sqrt(w * w + x * x + y * y + z * z) + 1.0e-9;
        w = w / n; x = x / n; y = y / n; z = z / n;
        r = '{1 - 2 * (y * y + z * z), 2 * (x * y - z * w), 2 * (x * z + y * w),
              2 * (x * y + z * w), 1 - 2 * (x * x + z * z), 2 * (y * z - x * w),
              2 * (x * z - y * w), 2 * (y * z + x * w), 1 - 2 * (x * x + y * y)};
        for (int k = 0; k < 9; k++)
            a.m[k] = 16'($rtoi(r[k] * 16384.0) + int'($urandom_range(0, 4)) - 2);
        return a;
    endfunction

    // Result checker: the receiver cannot stall, so every strobe is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (quat_queue.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                t_quat w;
                w = quat_queue.pop_front();
                if (o_q_x !== w.qx) report_mismatch("q_x", o_q_x, w.qx);
                if (o_q_y !== w.qy) report_mismatch("q_y", o_q_y, w.qy);
                if (o_q_z !== w.qz) report_mismatch("q_z", o_q_z, w.qz);
                if (o_q_w !== w.qw) report_mismatch("q_w", o_q_w, w.qw);
                if (o_bad_input !== w.bad) report_mismatch("bad_input", o_bad_input, w.bad);
            end
        end
    end

    initial begin
        t_row rows [$];
        t_row r;
        t_mat a;
        t_quat z;
        z = '{default: '0};
        // Identity gives w = 1, and an all-zero matrix takes the z branch with z = 1/2.
        r.typed = 1; r.mat = build(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
        r.res = '{0, 0, 0, 16384, 0}; rows.push_back(r);
        r.mat = build(0, 0, 0, 0, 0, 0, 0, 0, 0);
        r.res = '{0, 0, 8192, 0, 0}; rows.push_back(r);
        r.typed = 0;
        // Very negative diagonals, with ties sending the choice to the z branch.
        r.mat = build(-32768, 7, 9, 1, -32768, 3, 5, 2, -32768);
        r.res = z; rows.push_back(r);
        r.mat = build(-32768, 0, 0, 0, -32768, 0, 0, 0, -32767);
        r.res = z; rows.push_back(r);
        // Half turns about each axis, ties on the diagonal, extremes.
        rows.push_back('{build(16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 0, z});
        rows.push_back('{build(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384), 0, z});
        rows.push_back('{build(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384), 0, z});
        rows.push_back('{build(-8192, 100, 200, 300, -8192, 400, 500, 600, -8192), 0, z});
        rows.push_back('{build(0, 5, 0, 0, 0, 0, 0, 0, -100), 0, z});
        rows.push_back('{build(-100, 0, 0, 0, 0, 0, 0, 0, 0), 0, z});
        rows.push_back('{build(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 0, z});
        rows.push_back('{build(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                               -32768, -32768), 0, z});
        rows.push_back('{build(-16384, 32767, -32768, -32768, -16384, 32767, 32767,
                               -32768, -16384), 0, z});
        rows.push_back('{build(-32768, 32767, 32767, 32767, -32768, 32767, 32767,
                               32767, -16383), 0, z});
        rows.push_back('{build(1, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0), 0, z});
        rows.push_back('{build(0, 0, 0, 0, 0, 0, 0, 0, -16383), 0, z});
        rows.push_back('{build(0, 0, 0, 0, -32768, 0, 0, 0, 32767), 0, z});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[k]) begin
            if (!rows[k].typed) rows[k].res = quat_of(rows[k].mat);
            send_matrix(rows[k].mat, rows[k].res, 1'b1);
        end
        for (int n = 0; n < N_RAND; n++) begin
            a = ($urandom_range(0, 9) < 7) ? rotation_mat() : noise_mat();
            send_matrix(a, quat_of(a), n < N_RAND - 200);
        end
        start <= 1'b0;
        while (quat_queue.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        stim_done = 1'b1;
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        if (!stim_done) begin
            $display("Simulation FAILED");
            $finish;
        end
    end
endmodule

FILE: filelist.f
rtl/core/rmq_pkg.sv
rtl/core/rmq_front.sv
rtl/core/rmq_fifo.sv
rtl/core/rmq_back.sv
rtl/core/rotation_matrix_to_quaternion_core.sv
bench/tb_top.sv
